// ----- design/pat_pkg.sv -----
package pat_pkg;

   // table geometry
   localparam int PID_MAX       = 1024;
   localparam int PID_BITS      = 10;
   localparam int HANDLE_BITS   = 16;
   localparam int WORD_BITS     = 32;
   localparam int BIT_IDX_BITS  = $clog2(WORD_BITS);
   localparam int WORDS         = PID_MAX / WORD_BITS;
   localparam int WORD_IDX_BITS = PID_BITS - BIT_IDX_BITS;
   localparam int ITER_BITS     = $clog2(WORDS + 1);

   // request functions
   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_FIND    = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   // scan window over one map word
   localparam logic [1:0] WIN_UPPER = 2'd0;
   localparam logic [1:0] WIN_FULL  = 2'd1;
   localparam logic [1:0] WIN_LOWER = 2'd2;

   typedef struct packed {
      logic [1:0]             func;
      logic [PID_BITS-1:0]    pid;
      logic [HANDLE_BITS-1:0] task_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [PID_BITS-1:0]    out_pid;
      logic [HANDLE_BITS-1:0] out_handle;
   } rsp_type;

   typedef struct packed {
      logic [BIT_IDX_BITS-1:0] start_bit;
      logic [1:0]              window;
      logic                    exclude_zero;
   } scan_ctl_type;

   typedef struct packed {
      logic                    found;
      logic [BIT_IDX_BITS-1:0] bit_idx;
   } scan_res_type;

endpackage

// ----- design/pat_ram.sv -----
module pat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/pat_scan.sv -----
module pat_scan (
   input  logic [pat_pkg::WORD_BITS-1:0] map_word,
   input  pat_pkg::scan_ctl_type         ctl,
   output pat_pkg::scan_res_type         res
);

   logic [pat_pkg::WORD_BITS-1:0] upper_mask;
   logic [pat_pkg::WORD_BITS-1:0] mask;
   logic [pat_pkg::WORD_BITS-1:0] free_bits;

   // window mask: from the start bit up, everything, or below the start bit
   always_comb begin
      upper_mask = {pat_pkg::WORD_BITS{1'b1}} << ctl.start_bit;
      case (ctl.window)
         pat_pkg::WIN_UPPER: mask = upper_mask;
         pat_pkg::WIN_LOWER: mask = ~upper_mask;
         default:            mask = {pat_pkg::WORD_BITS{1'b1}};
      endcase
      // identifier zero is never handed out
      if (ctl.exclude_zero) begin
         mask[0] = 1'b0;
      end
      free_bits = ~map_word & mask;
   end

   // lowest free bit in the window
   always_comb begin
      res.found   = |free_bits;
      res.bit_idx = '0;
      for (int i = pat_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            res.bit_idx = pat_pkg::BIT_IDX_BITS'(i);
         end
      end
   end

endmodule

// ----- design/pid_allocator_table.sv -----
// pid_allocator_table: next-fit identifier allocator over identifiers 1..1023
//
// request channel: start with req_data (func, pid, task_handle); a
// transaction is taken at a rising edge with start high and busy low.
// response channel: rsp_strobe is high for exactly one cycle with rsp_data
// (status, out_pid, out_handle); the receiver cannot stall it, so no
// response is ever held back.
//
// release and find read the in-use map and the handle store at acceptance
// and answer from the check state. allocate scans the in-use map one 32-bit
// word per cycle through one shared find-first-free unit, starting at the
// next-fit pointer, until a free identifier is found or the last pass over
// the start word below the pointer reports the table exhausted. busy falls
// as the strobe rises, so the next transaction can be taken at the edge that ends the strobe cycle.
//
// reset: a clearing pass writes zero to all 32 words of the in-use map,
// one word a cycle, with busy high throughout. the pointer returns to
// one. handles are not cleared: one is read only after it was written.
module pid_allocator_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pat_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pat_pkg::rsp_type rsp_data
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_CHECK = 2'd3;

   localparam int WI = pat_pkg::WORD_IDX_BITS;
   localparam int BI = pat_pkg::BIT_IDX_BITS;
   localparam int PB = pat_pkg::PID_BITS;

   logic [1:0]                    state_ff, state_in;
   logic [WI-1:0]                 clr_ff, clr_in;
   logic [PB-1:0]                 ptr_ff, ptr_in;
   logic [pat_pkg::ITER_BITS-1:0] iter_ff, iter_in;
   logic [WI-1:0]                 word_ff, word_in;
   pat_pkg::req_type              req_ff, req_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pat_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           map_we;
   logic [WI-1:0]                  map_waddr, map_raddr;
   logic [pat_pkg::WORD_BITS-1:0]  map_wdata, map_rdata;
   logic                           hdl_we;
   logic [PB-1:0]                  hdl_waddr, hdl_raddr;
   logic [pat_pkg::HANDLE_BITS-1:0] hdl_rdata;

   pat_pkg::scan_ctl_type          scan_ctl;
   pat_pkg::scan_res_type          scan_res;
   logic [PB-1:0]                  found_pid;
   logic [pat_pkg::WORD_BITS-1:0]  pid_onehot;
   logic                           pid_ok;
   logic                           hit;

   // in-use map, one bit per identifier, 32 identifiers per word
   pat_ram #(
      .WIDTH(pat_pkg::WORD_BITS),
      .DEPTH(pat_pkg::WORDS)
   ) u_map_ram (
      .clock(clock),
      .we   (map_we),
      .waddr(map_waddr),
      .wdata(map_wdata),
      .raddr(map_raddr),
      .rdata(map_rdata)
   );

   // handle store, indexed by identifier
   pat_ram #(
      .WIDTH(pat_pkg::HANDLE_BITS),
      .DEPTH(pat_pkg::PID_MAX)
   ) u_handle_ram (
      .clock(clock),
      .we   (hdl_we),
      .waddr(hdl_waddr),
      .wdata(req_ff.task_handle),
      .raddr(hdl_raddr),
      .rdata(hdl_rdata)
   );

   // shared find-first-free unit
   pat_scan u_scan (
      .map_word(map_rdata),
      .ctl     (scan_ctl),
      .res     (scan_res)
   );

   // scan window follows the iteration: first word from the pointer up,
   // last pass over the same word below the pointer
   always_comb begin
      scan_ctl.start_bit    = ptr_ff[BI-1:0];
      scan_ctl.exclude_zero = (word_ff == '0);
      if (iter_ff == '0) begin
         scan_ctl.window = pat_pkg::WIN_UPPER;
      end else if (iter_ff == pat_pkg::ITER_BITS'(pat_pkg::WORDS)) begin
         scan_ctl.window = pat_pkg::WIN_LOWER;
      end else begin
         scan_ctl.window = pat_pkg::WIN_FULL;
      end
   end

   assign found_pid  = {word_ff, scan_res.bit_idx};
   assign pid_onehot = pat_pkg::WORD_BITS'(1) << req_ff.pid[BI-1:0];
   assign pid_ok     = (req_ff.pid != '0)
                       && ({1'b0, req_ff.pid} < (PB + 1)'(pat_pkg::PID_MAX));
   assign hit        = pid_ok && map_rdata[req_ff.pid[BI-1:0]];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      iter_in      = iter_ff;
      word_in      = word_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_we       = 1'b0;
      map_waddr    = word_ff;
      map_wdata    = map_rdata;
      map_raddr    = word_ff;
      hdl_we       = 1'b0;
      hdl_waddr    = found_pid;
      hdl_raddr    = req_ff.pid;
      case (state_ff)
         S_CLEAR: begin
            // clearing pass over the in-use map
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            clr_in    = clr_ff + WI'(1);
            if (clr_ff == WI'(pat_pkg::WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // read at the accept edge so data is ready next cycle
            hdl_raddr = req_data.pid;
            if (req_data.func == pat_pkg::FUNC_ALLOC) begin
               map_raddr = ptr_ff[PB-1:BI];
            end else begin
               map_raddr = req_data.pid[PB-1:BI];
            end
            if (start) begin
               req_in  = req_data;
               word_in = ptr_ff[PB-1:BI];
               iter_in = '0;
               if (req_data.func == pat_pkg::FUNC_ALLOC) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               // claim the identifier and store its handle
               map_we            = 1'b1;
               map_waddr         = word_ff;
               map_wdata         = map_rdata
                                   | (pat_pkg::WORD_BITS'(1) << scan_res.bit_idx);
               hdl_we            = 1'b1;
               if (found_pid == PB'(pat_pkg::PID_MAX - 1)) begin
                  ptr_in = PB'(1);
               end else begin
                  ptr_in = found_pid + PB'(1);
               end
               rsp_valid_in      = 1'b1;
               rsp_in.status     = pat_pkg::STAT_OK;
               rsp_in.out_pid    = found_pid;
               rsp_in.out_handle = '0;
               state_in          = S_IDLE;
            end else if (iter_ff == pat_pkg::ITER_BITS'(pat_pkg::WORDS)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = pat_pkg::STAT_EXHAUSTED;
               rsp_in.out_pid    = '0;
               rsp_in.out_handle = '0;
               state_in          = S_IDLE;
            end else begin
               // move on to the next word, wrapping round the table
               iter_in   = iter_ff + pat_pkg::ITER_BITS'(1);
               word_in   = word_ff + WI'(1);
               map_raddr = word_ff + WI'(1);
            end
         end
         S_CHECK: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = pat_pkg::STAT_OK;
            rsp_in.out_pid    = req_ff.pid;
            rsp_in.out_handle = '0;
            case (req_ff.func)
               pat_pkg::FUNC_RELEASE: begin
                  if (hit) begin
                     map_we    = 1'b1;
                     map_waddr = req_ff.pid[PB-1:BI];
                     map_wdata = map_rdata & ~pid_onehot;
                  end else begin
                     rsp_in.status = pat_pkg::STAT_NOT_FOUND;
                  end
               end
               pat_pkg::FUNC_FIND: begin
                  if (hit) begin
                     rsp_in.out_handle = hdl_rdata;
                  end else begin
                     rsp_in.status = pat_pkg::STAT_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_in.status = pat_pkg::STAT_OK;
               end
            endcase
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= PB'(1);
         iter_ff      <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         iter_ff      <= iter_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // an accepted transaction always moves the sequencer out of idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // the next-fit pointer never points at identifier zero
   a_ptr_nonzero: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != '0)
      else $error("next-fit pointer is zero");

   // no two response strobes come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   // exhausted allocation reports identifier zero
   a_exhausted_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == pat_pkg::STAT_EXHAUSTED)
      |-> (rsp_data.out_pid == '0))
      else $error("exhausted response carries an identifier");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   // func code with no operation behind it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 40;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      pat_pkg::req_type req;
      bit               typed;
      pat_pkg::rsp_type rsp;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   pat_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   pat_pkg::rsp_type rsp_data;

   // shadow of the identifier table
   bit          model_in_use [pat_pkg::PID_MAX];
   logic [15:0] model_handle [pat_pkg::PID_MAX];
   int unsigned model_next_ptr = 1;
   int          model_used_count = 0;

   pat_pkg::rsp_type pending_rsp [$];
   stim_row_type     directed_rows [$];
   int               mismatch_count = 0;
   longint           cycle_count = 0;
   int               idle_pct = 0;

   pid_allocator_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // next-fit allocation, release and lookup over the shadow table
   function automatic pat_pkg::rsp_type table_response(pat_pkg::req_type r);
      pat_pkg::rsp_type o;
      int unsigned      cand;
      bit               found;
      o.status     = pat_pkg::STAT_OK;
      o.out_pid    = r.pid;
      o.out_handle = '0;
      case (r.func)
         pat_pkg::FUNC_ALLOC: begin
            cand  = model_next_ptr;
            found = 1'b0;
            if (cand < 1 || cand >= pat_pkg::PID_MAX) cand = 1;
            for (int i = 0; i < pat_pkg::PID_MAX - 1; i++) begin
               if (!model_in_use[cand]) begin
                  found = 1'b1;
                  break;
               end
               cand++;
               if (cand >= pat_pkg::PID_MAX) cand = 1;
            end
            if (found) begin
               model_in_use[cand] = 1'b1;
               model_handle[cand] = r.task_handle;
               model_used_count++;
               model_next_ptr = (cand + 1 >= pat_pkg::PID_MAX) ? 1 : cand + 1;
               o.out_pid = cand[pat_pkg::PID_BITS-1:0];
            end else begin
               o.status  = pat_pkg::STAT_EXHAUSTED;
               o.out_pid = '0;
            end
         end
         pat_pkg::FUNC_RELEASE: begin
            if (r.pid != 0 && model_in_use[r.pid]) begin
               model_in_use[r.pid] = 1'b0;
               model_used_count--;
            end else begin
               o.status = pat_pkg::STAT_NOT_FOUND;
            end
         end
         pat_pkg::FUNC_FIND: begin
            if (r.pid != 0 && model_in_use[r.pid]) o.out_handle = model_handle[r.pid];
            else o.status = pat_pkg::STAT_NOT_FOUND;
         end
         default: ;
      endcase
      return o;
   endfunction

   // one transaction: hold start until taken, then log the expected response
   task automatic send_req(pat_pkg::req_type r, bit typed, pat_pkg::rsp_type typed_rsp);
      pat_pkg::rsp_type predicted;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = table_response(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_op(logic [1:0] func, logic [pat_pkg::PID_BITS-1:0] pid,
                          logic [15:0] handle);
      pat_pkg::req_type r;
      r.func        = func;
      r.pid         = pid;
      r.task_handle = handle;
      send_req(r, 1'b0, '0);
   endtask

   // hold off until every response is back
   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // mostly identifiers in use, otherwise any 10-bit value
   function automatic logic [pat_pkg::PID_BITS-1:0] pick_pid();
      int unsigned cand;
      if ($urandom_range(99) < 80 && model_used_count > 0) begin
         for (int i = 0; i < 64; i++) begin
            cand = $urandom_range(pat_pkg::PID_MAX - 1, 1);
            if (model_in_use[cand]) return cand[pat_pkg::PID_BITS-1:0];
         end
      end
      return pat_pkg::PID_BITS'($urandom_range(pat_pkg::PID_MAX - 1, 0));
   endfunction

   function automatic void add_row(logic [1:0] func, logic [pat_pkg::PID_BITS-1:0] pid,
                                   logic [15:0] handle, bit typed, logic [1:0] status,
                                   logic [pat_pkg::PID_BITS-1:0] out_pid,
                                   logic [15:0] out_handle);
      stim_row_type row;
      row.req.func        = func;
      row.req.pid         = pid;
      row.req.task_handle = handle;
      row.typed           = typed;
      row.rsp.status      = status;
      row.rsp.out_pid     = out_pid;
      row.rsp.out_handle  = out_handle;
      directed_rows.push_back(row);
   endfunction

   // response check against the oldest expectation
   always @(posedge clock) begin
      pat_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no transaction outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.out_pid !== want.out_pid) begin
               $error("out_pid: expected %0d, got %0d", want.out_pid, rsp_data.out_pid);
               mismatch_count++;
            end
            if (rsp_data.out_handle !== want.out_handle) begin
               $error("out_handle: expected %h, got %h", want.out_handle, rsp_data.out_handle);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned op;
      foreach (model_in_use[i]) model_in_use[i] = 1'b0;

      // directed rows: out-of-range and free identifiers, unused func, first allocations
      add_row(pat_pkg::FUNC_FIND, 10'd1, 16'h0000,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd1, 16'h0000);
      add_row(pat_pkg::FUNC_RELEASE, 10'd0, 16'hffff,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd0, 16'h0000);
      add_row(pat_pkg::FUNC_FIND, 10'd0, 16'hffff,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd0, 16'h0000);
      add_row(pat_pkg::FUNC_RELEASE, 10'd1023, 16'h0000,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd1023, 16'h0000);
      add_row(pat_pkg::FUNC_FIND, 10'd1023, 16'h0000,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd1023, 16'h0000);
      add_row(FUNC_UNUSED, 10'd1023, 16'hffff,
              1'b1, pat_pkg::STAT_OK, 10'd1023, 16'h0000);
      add_row(pat_pkg::FUNC_ALLOC, 10'd1023, 16'hffff,
              1'b1, pat_pkg::STAT_OK, 10'd1, 16'h0000);
      add_row(pat_pkg::FUNC_ALLOC, 10'd0, 16'h0000,
              1'b1, pat_pkg::STAT_OK, 10'd2, 16'h0000);
      add_row(pat_pkg::FUNC_FIND, 10'd1, 16'h0000,
              1'b1, pat_pkg::STAT_OK, 10'd1, 16'hffff);
      add_row(pat_pkg::FUNC_FIND, 10'd2, 16'hffff,
              1'b1, pat_pkg::STAT_OK, 10'd2, 16'h0000);
      add_row(pat_pkg::FUNC_RELEASE, 10'd1, 16'h0000,
              1'b1, pat_pkg::STAT_OK, 10'd1, 16'h0000);
      add_row(pat_pkg::FUNC_RELEASE, 10'd1, 16'h0000,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd1, 16'h0000);
      add_row(pat_pkg::FUNC_FIND, 10'd1, 16'h0000,
              1'b1, pat_pkg::STAT_NOT_FOUND, 10'd1, 16'h0000);
      add_row(pat_pkg::FUNC_ALLOC, 10'd5, 16'ha5a5,
              1'b0, pat_pkg::STAT_OK, 10'd0, 16'h0000);
      add_row(pat_pkg::FUNC_FIND, 10'd3, 16'h0000,
              1'b0, pat_pkg::STAT_OK, 10'd0, 16'h0000);
      add_row(FUNC_UNUSED, 10'd0, 16'h0000,
              1'b1, pat_pkg::STAT_OK, 10'd0, 16'h0000);
      add_row(pat_pkg::FUNC_ALLOC, 10'd0, 16'h5a5a,
              1'b0, pat_pkg::STAT_OK, 10'd0, 16'h0000);
      add_row(pat_pkg::FUNC_RELEASE, 10'd4, 16'h0000,
              1'b0, pat_pkg::STAT_OK, 10'd0, 16'h0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_req(directed_rows[i].req, directed_rows[i].typed,
                                          directed_rows[i].rsp);
      drain();

      // fill the table until exhausted with light sender idling;
      // the pointer wraps past the top identifier
      idle_pct = 28;
      while (model_used_count < pat_pkg::PID_MAX - 1) begin
         send_op(pat_pkg::FUNC_ALLOC, pat_pkg::PID_BITS'($urandom), 16'($urandom));
      end
      repeat (2) send_op(pat_pkg::FUNC_ALLOC, pat_pkg::PID_BITS'($urandom), 16'($urandom));
      send_op(pat_pkg::FUNC_FIND, 10'd1023, 16'h0000);
      drain();

      // random phases over the full table: sender idling heavy, then none
      for (int phase = 1; phase < 3; phase++) begin
         idle_pct = (phase == 1) ? 47 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op = $urandom_range(99);
            if (op < 45) begin
               send_op(pat_pkg::FUNC_ALLOC, pat_pkg::PID_BITS'($urandom), 16'($urandom));
            end else if (op < 75) begin
               send_op(pat_pkg::FUNC_RELEASE, pick_pid(), 16'($urandom));
            end else if (op < 95) begin
               send_op(pat_pkg::FUNC_FIND, pick_pid(), 16'($urandom));
            end else begin
               send_op(FUNC_UNUSED, pat_pkg::PID_BITS'($urandom), 16'($urandom));
            end
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/pat_pkg.sv
design/pat_ram.sv
design/pat_scan.sv
design/pid_allocator_table.sv
tb/testbench.sv
